// ===== hw/rtl/mst_pkg.sv =====
// shared types, constants and command codes for the min tracking stack
`timescale 1ns / 1ps
`default_nettype none

package mst_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int VALUE_W   = 32;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                accept;
    logic                push;
    logic                pop;
    logic                rd;
    logic                load;
    logic                emit;
    logic [STATUS_W-1:0] status;
  } ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic single;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mst_ram.sv =====
// generic single port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module mst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mst_ctrl.sv =====
// controller state machine for the min tracking stack
`timescale 1ns / 1ps
`default_nettype none

module mst_ctrl
  import mst_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [CMD_W-1:0] cmd,
  input  wire dp_stat_t         stat,
  output ctrl_t                 ctrl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid && stat.out_free) begin
          if (cmd == CMD_POP && !stat.empty && !stat.single) begin
            state_next = ST_LOAD;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_LOAD: state_next = ST_EMIT;
      ST_EMIT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl     = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready    = stat.out_free;
        ctrl.accept = s_tvalid && stat.out_free;
        if (ctrl.accept) begin
          if (cmd == CMD_PUSH) begin
            if (stat.full) begin
              ctrl.status = STATUS_FULL;
            end else begin
              ctrl.push = 1'b1;
            end
          end else if (cmd == CMD_POP) begin
            if (stat.empty) begin
              ctrl.status = STATUS_EMPTY;
            end else begin
              ctrl.pop = 1'b1;
              ctrl.rd  = !stat.single;
            end
          end
        end
      end
      ST_LOAD: ctrl.load = 1'b1;
      ST_EMIT: ctrl.emit = 1'b1;
      default: ctrl = '0;
    endcase
  end

  // a load always takes the ram data of the read issued in the previous cycle
  assert property (@(posedge clk) disable iff (rst) ctrl.load |-> $past(ctrl.rd))
    else $error("load without a preceding read");

  // each accepted beat gets one emit; checked here as no two emits back to back
  assert property (@(posedge clk) disable iff (rst) ctrl.emit |=> !ctrl.emit)
    else $error("two emits back to back");

endmodule

`default_nettype wire

// ===== hw/rtl/mst_dp.sv =====
// datapath: pointer, top and minimum registers, level ram and result register
`timescale 1ns / 1ps
`default_nettype none

module mst_dp
  import mst_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int PTR_W = $clog2(DEPTH + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire ctrl_t                     ctrl,
  output dp_stat_t                       stat,
  input  wire logic signed [VALUE_W-1:0] push_value,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic signed [VALUE_W-1:0]      top_value,
  output logic signed [VALUE_W-1:0]      min_value,
  output logic [PTR_W-1:0]               occupancy,
  output logic                           is_empty,
  output logic [STATUS_W-1:0]            status
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int WORD_W = 2 * VALUE_W;

  logic [PTR_W-1:0]          sp;
  logic signed [VALUE_W-1:0] top_r;
  logic signed [VALUE_W-1:0] min_r;
  logic [STATUS_W-1:0]       status_r;
  logic signed [VALUE_W-1:0] min_next;
  logic [PTR_W-1:0]          sp_m1;
  logic [PTR_W-1:0]          sp_m2;
  logic                      ram_en;
  logic [ADDR_W-1:0]         ram_addr;
  logic [WORD_W-1:0]         ram_rdata;

  assign stat.full     = (sp == PTR_W'(DEPTH));
  assign stat.empty    = (sp == '0);
  assign stat.single   = (sp == PTR_W'(1));
  assign stat.out_free = !m_tvalid || m_tready;

  assign sp_m1    = sp - PTR_W'(1);
  assign sp_m2    = sp - PTR_W'(2);
  assign ram_en   = (ctrl.push && !stat.empty) || ctrl.rd;
  assign ram_addr = ctrl.push ? sp_m1[ADDR_W-1:0] : sp_m2[ADDR_W-1:0];
  assign min_next = (stat.empty || push_value < min_r) ? push_value : min_r;

  mst_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .en   (ram_en),
    .we   (ctrl.push),
    .addr (ram_addr),
    .wdata({min_r, top_r}),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (ctrl.push) begin
      sp <= sp + PTR_W'(1);
    end else if (ctrl.pop) begin
      sp <= sp_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      top_r <= push_value;
      min_r <= min_next;
    end else if (ctrl.load) begin
      top_r <= ram_rdata[VALUE_W-1:0];
      min_r <= ram_rdata[WORD_W-1:VALUE_W];
    end
    if (ctrl.accept) begin
      status_r <= ctrl.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      top_value <= stat.empty ? '0 : top_r;
      min_value <= stat.empty ? '0 : min_r;
      occupancy <= sp;
      is_empty  <= stat.empty;
      status    <= status_r;
    end
  end

  assert property (@(posedge clk) disable iff (rst) sp <= PTR_W'(DEPTH))
    else $error("stack pointer beyond depth");

  assert property (@(posedge clk) disable iff (rst) ctrl.push |-> !stat.full && !ctrl.pop)
    else $error("push on a full stack");

  // the result register never overwrites a beat that has not been taken
  assert property (@(posedge clk) disable iff (rst) ctrl.emit |-> stat.out_free)
    else $error("result beat overwritten");

  assert property (@(posedge clk) disable iff (rst) ctrl.rd |-> ctrl.pop && sp > PTR_W'(1))
    else $error("level read without a level below the top");

endmodule

`default_nettype wire

// ===== hw/rtl/min_tracking_stack_core.sv =====
// top level of the min tracking stack
`timescale 1ns / 1ps
`default_nettype none

// Stack of signed 32-bit values that also reports the minimum of everything
// held. Each input beat is a push, a pop or a query and returns one output beat
// showing top, minimum, occupancy and status after the operation. The top value
// and its minimum live in registers, the lower levels in one single port ram
// with a registered read. One beat is in flight at a time: a push or query
// passes the emit state, a pop that uncovers a lower level also passes the load
// state to fetch that level from the ram. A refused push (full) or pop (empty)
// leaves the stack unchanged. No clearing pass is needed after reset.
module min_tracking_stack_core
  import mst_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int PTR_W = $clog2(DEPTH + 1),
  parameter int OUT_W = ((2 * VALUE_W + PTR_W + 1 + 7) / 8) * 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [VALUE_W-1:0] s_tdata,  // push_value
  input  wire logic [CMD_W-1:0]   s_tuser,  // cmd
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [OUT_W-1:0]        m_tdata,  // top_value, min_value, occupancy, is_empty
  output logic [STATUS_W-1:0]     m_tuser   // status
);

  ctrl_t                     ctrl;
  dp_stat_t                  stat;
  logic signed [VALUE_W-1:0] top_value;
  logic signed [VALUE_W-1:0] min_value;
  logic [PTR_W-1:0]          occupancy;
  logic                      is_empty;

  mst_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .cmd     (s_tuser),
    .stat    (stat),
    .ctrl    (ctrl)
  );

  mst_dp #(
    .DEPTH(DEPTH),
    .PTR_W(PTR_W)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .stat      (stat),
    .push_value(s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .top_value (top_value),
    .min_value (min_value),
    .occupancy (occupancy),
    .is_empty  (is_empty),
    .status    (m_tuser)
  );

  assign m_tdata = OUT_W'({is_empty, occupancy, min_value, top_value});

endmodule

`default_nettype wire

// ===== tb/min_tracking_stack_core_test.sv =====
// self-checking testbench for min_tracking_stack_core: directed table, then random push/pop/query traffic
`timescale 1ns / 1ps

module min_tracking_stack_core_test
  import mst_pkg::*;
;

  localparam int STACK_DEPTH = DEPTH_DEF;
  localparam int PTR_W = $clog2(STACK_DEPTH + 1);
  localparam int OUT_W = ((2 * VALUE_W + PTR_W + 1 + 7) / 8) * 8;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int SCRIPT_LEN = 23;

  typedef struct packed {
    logic [VALUE_W-1:0]  top_value;
    logic [VALUE_W-1:0]  min_value;
    logic [PTR_W-1:0]    occupancy;
    logic                is_empty;
    logic [STATUS_W-1:0] status;
  } stack_view_t;

  typedef struct packed {
    logic [CMD_W-1:0]   op;
    logic [VALUE_W-1:0] value;
    logic               typed;
    stack_view_t        want;
  } script_row_t;

  localparam stack_view_t EMPTY_OK  = '{32'd0, 32'd0, 11'd0, 1'b1, STATUS_OK};
  localparam stack_view_t EMPTY_ERR = '{32'd0, 32'd0, 11'd0, 1'b1, STATUS_EMPTY};
  localparam stack_view_t ONE_MAX   = '{32'h7fff_ffff, 32'h7fff_ffff, 11'd1, 1'b0, STATUS_OK};
  localparam stack_view_t TWO_MIN   = '{32'h8000_0000, 32'h8000_0000, 11'd2, 1'b0, STATUS_OK};
  localparam stack_view_t NO_VIEW   = '0;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [VALUE_W-1:0] s_tdata = '0;   // push_value
  logic [CMD_W-1:0]   s_tuser = '0;   // cmd
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [OUT_W-1:0]   m_tdata;        // top_value, min_value, occupancy, is_empty
  logic [STATUS_W-1:0] m_tuser;       // status

  int src_idle = 0;
  int dst_idle = 0;
  int fail_count = 0;
  int stall_cycles = 0;

  logic [VALUE_W-1:0] shadow_vals [STACK_DEPTH];
  logic [VALUE_W-1:0] shadow_mins [STACK_DEPTH];
  int                 shadow_depth = 0;
  stack_view_t        pending_views [$];
  stack_view_t        want_view;
  stack_view_t        got_view;

  script_row_t script [SCRIPT_LEN] = '{
    '{CMD_QUERY, 32'd0,         1'b1, EMPTY_OK},
    '{CMD_POP,   32'd0,         1'b1, EMPTY_ERR},
    '{CMD_SPARE, 32'hffff_ffff, 1'b1, EMPTY_OK},
    '{CMD_PUSH,  32'h7fff_ffff, 1'b1, ONE_MAX},
    '{CMD_PUSH,  32'h8000_0000, 1'b1, TWO_MIN},
    '{CMD_PUSH,  32'd0,         1'b0, NO_VIEW},
    '{CMD_PUSH,  32'hffff_ffff, 1'b0, NO_VIEW},
    '{CMD_QUERY, 32'h5555_5555, 1'b0, NO_VIEW},
    '{CMD_SPARE, 32'haaaa_aaaa, 1'b0, NO_VIEW},
    '{CMD_POP,   32'd0,         1'b0, NO_VIEW},
    '{CMD_POP,   32'd0,         1'b0, NO_VIEW},
    '{CMD_POP,   32'd0,         1'b0, NO_VIEW},
    '{CMD_POP,   32'd0,         1'b1, EMPTY_OK},
    '{CMD_POP,   32'd0,         1'b1, EMPTY_ERR},
    '{CMD_PUSH,  32'd5,         1'b0, NO_VIEW},
    '{CMD_PUSH,  32'd5,         1'b0, NO_VIEW},
    '{CMD_PUSH,  32'd6,         1'b0, NO_VIEW},
    '{CMD_PUSH,  32'd4,         1'b0, NO_VIEW},
    '{CMD_POP,   32'd0,         1'b0, NO_VIEW},
    '{CMD_POP,   32'd0,         1'b0, NO_VIEW},
    '{CMD_POP,   32'd0,         1'b0, NO_VIEW},
    '{CMD_POP,   32'd0,         1'b1, EMPTY_OK},
    '{CMD_QUERY, 32'd0,         1'b1, EMPTY_OK}
  };

  min_tracking_stack_core #(
    .DEPTH(STACK_DEPTH)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always #1 clk = ~clk;

  // next stack view after one command, updating the shadow stack
  function automatic stack_view_t stack_after(input logic [CMD_W-1:0] op,
                                              input logic [VALUE_W-1:0] val);
    stack_view_t view;
    logic [VALUE_W-1:0] level_min;
    view = '0;
    view.status = STATUS_OK;
    if (op == CMD_PUSH) begin
      if (shadow_depth >= STACK_DEPTH) begin
        view.status = STATUS_FULL;
      end else begin
        level_min = val;
        if (shadow_depth > 0 && $signed(shadow_mins[shadow_depth-1]) < $signed(val)) begin
          level_min = shadow_mins[shadow_depth-1];
        end
        shadow_vals[shadow_depth] = val;
        shadow_mins[shadow_depth] = level_min;
        shadow_depth++;
      end
    end else if (op == CMD_POP) begin
      if (shadow_depth == 0) begin
        view.status = STATUS_EMPTY;
      end else begin
        shadow_depth--;
      end
    end
    if (shadow_depth > 0) begin
      view.top_value = shadow_vals[shadow_depth-1];
      view.min_value = shadow_mins[shadow_depth-1];
    end
    view.occupancy = shadow_depth[PTR_W-1:0];
    view.is_empty = (shadow_depth == 0);
    return view;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return 32'hffff_ffff;
      4, 5: return $urandom_range(16) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_beat(input logic [CMD_W-1:0] op, input logic [VALUE_W-1:0] val,
                            input logic typed, input stack_view_t typed_view);
    stack_view_t view;
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= val;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    view = stack_after(op, val);
    pending_views.push_back(typed ? typed_view : view);
  endtask

  task automatic random_beat(input int push_pct, input int pop_pct);
    int roll;
    logic [CMD_W-1:0] op;
    roll = $urandom_range(99);
    if (roll < push_pct) op = CMD_PUSH;
    else if (roll < push_pct + pop_pct) op = CMD_POP;
    else if ($urandom_range(3) == 0) op = CMD_SPARE;
    else op = CMD_QUERY;
    queue_beat(op, pick_value(), 1'b0, NO_VIEW);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_views.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= dst_idle);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_view.top_value = m_tdata[VALUE_W-1:0];
      got_view.min_value = m_tdata[2*VALUE_W-1:VALUE_W];
      got_view.occupancy = m_tdata[2*VALUE_W+PTR_W-1:2*VALUE_W];
      got_view.is_empty = m_tdata[2*VALUE_W+PTR_W];
      got_view.status = m_tuser;
      if (pending_views.size() == 0) begin
        $error("result beat with nothing pending");
        fail_count = fail_count + 1;
      end else begin
        want_view = pending_views.pop_front();
        if (got_view.top_value !== want_view.top_value) begin
          $error("top_value: expected %0d, got %0d",
                 $signed(want_view.top_value), $signed(got_view.top_value));
          fail_count = fail_count + 1;
        end
        if (got_view.min_value !== want_view.min_value) begin
          $error("min_value: expected %0d, got %0d",
                 $signed(want_view.min_value), $signed(got_view.min_value));
          fail_count = fail_count + 1;
        end
        if (got_view.occupancy !== want_view.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want_view.occupancy, got_view.occupancy);
          fail_count = fail_count + 1;
        end
        if (got_view.is_empty !== want_view.is_empty) begin
          $error("is_empty: expected %0d, got %0d", want_view.is_empty, got_view.is_empty);
          fail_count = fail_count + 1;
        end
        if (got_view.status !== want_view.status) begin
          $error("status: expected %0d, got %0d", want_view.status, got_view.status);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    src_idle = 24;
    dst_idle = 80;
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      queue_beat(script[i].op, script[i].value, script[i].typed, script[i].want);
    end

    // hover near empty, then climb to half depth
    repeat (20) random_beat(40, 45);
    while (shadow_depth < STACK_DEPTH / 2) random_beat(98, 1);
    wait_drained();

    // fill to the top, push into a full stack, then unwind a little
    src_idle = 80;
    dst_idle = 24;
    while (shadow_depth < STACK_DEPTH) random_beat(98, 1);
    repeat (4) queue_beat(CMD_PUSH, pick_value(), 1'b0, NO_VIEW);
    repeat (12) random_beat(20, 70);
    wait_drained();

    src_idle = 0;
    dst_idle = 0;
    repeat (24) begin
      if ($urandom_range(7) == 0) wait_drained();
      random_beat(30, 60);
    end

    s_tvalid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
